@@ hdl/upsmon_pkg.sv @@
`default_nettype none

package upsmon_pkg;

	// Field and state widths fixed by the line interface.
	localparam int GRACE_W = 15;
	localparam int FAIL_W  = 16;
	localparam int SECS_W  = 17;
	localparam int COUNT_W = 3;

	// Grace period after reset, in two-second ticks.
	localparam logic [GRACE_W-1:0] GRACE_RESET = 15'd120;

endpackage

`default_nettype wire

@@ hdl/ups_power_fail_monitor.sv @@
`default_nettype none

// UPS power-fail monitor. Each input beat is one sample of the mains-fail and
// battery-ok lines and produces exactly one result beat in the next cycle. A
// status change must be seen on CONFIRM_SAMPLES consecutive samples before it
// is acted on; until then the result flags held_sample and the host should
// resample after one second. Mains failure with a low battery demands
// shutdown at once; mains failure alone counts two-second ticks against
// grace_ticks, warning on the first tick and every REPORT_INTERVAL-th, and
// demands shutdown when the grace is used up. The shutdown flag stays set
// until reset. The block takes one sample per clock: all work is a single
// combinational pass from the state registers to the result register, and a new sample
// is taken whenever the result register is empty or being read in the same cycle. The user
// writes grace_ticks on the cfg channel while idle; the block does not enforce it.
module ups_power_fail_monitor #(
	parameter int CONFIRM_SAMPLES = 4,
	parameter int REPORT_INTERVAL = 30
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [upsmon_pkg::GRACE_W-1:0]      grace_ticks,
	// Sample channel.
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                mains_fail,
	input  wire logic                                battery_ok,
	// Result channel.
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     held_sample,
	output logic                                     power_ok,
	output logic                                     fail_warning,
	output logic signed [upsmon_pkg::SECS_W-1:0]     seconds_left,
	output logic                                     power_restored,
	output logic                                     shutdown
);

	localparam int REP_W = (REPORT_INTERVAL > 1) ? $clog2(REPORT_INTERVAL) : 1;
	localparam logic [REP_W-1:0] REP_LAST = REP_W'(REPORT_INTERVAL - 1);
	localparam logic [upsmon_pkg::COUNT_W-1:0] CONFIRM =
		upsmon_pkg::COUNT_W'(CONFIRM_SAMPLES);

	// State registers.
	logic [upsmon_pkg::GRACE_W-1:0] grace_q;
	logic                           last_pwr_q;
	logic                           last_bat_q;
	logic [upsmon_pkg::COUNT_W-1:0] change_count_q;
	logic [upsmon_pkg::FAIL_W-1:0]  fail_ticks_q;
	logic [REP_W-1:0]               rep_phase_q;
	logic                           shutdown_q;

	// Result register.
	logic                           out_valid_q;
	logic                           held_q;
	logic                           power_ok_q;
	logic                           warn_q;
	logic [upsmon_pkg::SECS_W-1:0]  secs_q;
	logic                           restored_q;
	logic                           shutdown_out_q;

	// Next-state and result values for the current sample.
	logic                           pwr;
	logic                           changed;
	logic                           held;
	logic [upsmon_pkg::COUNT_W-1:0] count_inc;
	logic [upsmon_pkg::COUNT_W-1:0] count_nxt;
	logic [upsmon_pkg::FAIL_W-1:0]  fail_nxt;
	logic [REP_W-1:0]               rep_nxt;
	logic                           sd_nxt;
	logic                           warn;
	logic                           restored;
	logic [upsmon_pkg::FAIL_W-1:0]  diff;
	logic [upsmon_pkg::SECS_W-1:0]  secs;
	logic                           in_beat;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_beat   = in_valid && in_ready;

	// Debounce and countdown decision for one sample.
	always_comb begin
		pwr       = !mains_fail;
		changed   = (pwr != last_pwr_q) || (battery_ok != last_bat_q);
		count_inc = change_count_q + 1'b1;
		held      = changed && (count_inc < CONFIRM);
		count_nxt = held ? count_inc : '0;
		fail_nxt  = fail_ticks_q;
		rep_nxt   = rep_phase_q;
		sd_nxt    = shutdown_q;
		warn      = 1'b0;
		restored  = 1'b0;
		secs      = '0;
		diff      = {1'b0, grace_q} - fail_ticks_q;
		if (!held) begin
			if (!pwr && !battery_ok) begin
				sd_nxt = 1'b1;
			end else if (!pwr) begin
				if (fail_ticks_q == '0 || rep_phase_q == '0) begin
					warn = 1'b1;
					secs = {diff, 1'b0};
				end
				if (fail_ticks_q > {1'b0, grace_q}) begin
					sd_nxt = 1'b1;
				end else begin
					fail_nxt = fail_ticks_q + 1'b1;
					rep_nxt  = (rep_phase_q == REP_LAST) ? '0 : rep_phase_q + 1'b1;
				end
			end else if (fail_ticks_q != '0) begin
				restored = 1'b1;
				fail_nxt = '0;
				rep_nxt  = '0;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q <= upsmon_pkg::GRACE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			grace_q <= grace_ticks;
		end
	end

	// Monitor state, updated once per accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pwr_q     <= 1'b1;
			last_bat_q     <= 1'b1;
			change_count_q <= '0;
			fail_ticks_q   <= '0;
			rep_phase_q    <= '0;
			shutdown_q     <= 1'b0;
		end else if (in_beat) begin
			change_count_q <= count_nxt;
			if (!held) begin
				last_pwr_q   <= pwr;
				last_bat_q   <= battery_ok;
				fail_ticks_q <= fail_nxt;
				rep_phase_q  <= rep_nxt;
				shutdown_q   <= sd_nxt;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			held_q         <= held;
			power_ok_q     <= held ? last_pwr_q : pwr;
			warn_q         <= warn;
			secs_q         <= secs;
			restored_q     <= restored;
			shutdown_out_q <= held ? shutdown_q : sd_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign held_sample    = held_q;
	assign power_ok       = power_ok_q;
	assign fail_warning   = warn_q;
	assign seconds_left   = secs_q;
	assign power_restored = restored_q;
	assign shutdown       = shutdown_out_q;

endmodule

`default_nettype wire

@@ hdl/upsmon_checker.sv @@
`default_nettype none

module upsmon_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic                                held_sample,
	input wire logic                                power_ok,
	input wire logic                                fail_warning,
	input wire logic signed [upsmon_pkg::SECS_W-1:0] seconds_left,
	input wire logic                                power_restored,
	input wire logic                                shutdown
);

	// Set once any delivered result has shown a shutdown demand.
	logic seen_shutdown_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_shutdown_q <= 1'b0;
		end else if (out_valid && out_ready && shutdown) begin
			seen_shutdown_q <= 1'b1;
		end
	end

	// Shutdown never clears before reset.
	a_shutdown_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_shutdown_q |-> shutdown)
		else $error("shutdown dropped after being demanded");

	// A held sample reports nothing beyond status.
	a_held_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held_sample |-> !fail_warning && !power_restored &&
			seconds_left == '0)
		else $error("held sample carries a report");

	// Seconds left is only given with a warning, and warnings only on failed mains.
	a_warn_secs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fail_warning |-> seconds_left == '0)
		else $error("seconds_left set without warning");

	a_warn_restore: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fail_warning || power_restored) |->
			(fail_warning != power_restored) && (power_ok == power_restored))
		else $error("warning or restore inconsistent with mains status");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(held_sample) &&
			$stable(power_ok) && $stable(fail_warning) && $stable(seconds_left) &&
			$stable(power_restored) && $stable(shutdown))
		else $error("result beat changed while stalled");

endmodule

bind ups_power_fail_monitor upsmon_checker u_upsmon_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.held_sample    (held_sample),
	.power_ok       (power_ok),
	.fail_warning   (fail_warning),
	.seconds_left   (seconds_left),
	.power_restored (power_restored),
	.shutdown       (shutdown)
);

`default_nettype wire

@@ tb/ups_power_fail_monitor_tb.sv @@
`timescale 1ns / 1ps

module ups_power_fail_monitor_tb;

	localparam int GRACE_W = upsmon_pkg::GRACE_W;
	localparam int FAIL_W  = upsmon_pkg::FAIL_W;
	localparam int SECS_W  = upsmon_pkg::SECS_W;
	localparam int COUNT_W = upsmon_pkg::COUNT_W;

	localparam int CONFIRM_SAMPLES = 4;
	localparam int REPORT_INTERVAL = 30;
	localparam logic [GRACE_W-1:0] GRACE_MAX = '1;

	// One result beat as the monitor reports it.
	typedef struct packed {
		logic                     held;
		logic                     pwr_ok;
		logic                     warn;
		logic signed [SECS_W-1:0] secs;
		logic                     restored;
		logic                     shut;
	} ups_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [GRACE_W-1:0] grace_ticks = upsmon_pkg::GRACE_RESET;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mains_fail = 1'b0;
	logic battery_ok = 1'b1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic held_sample;
	logic power_ok;
	logic fail_warning;
	logic signed [SECS_W-1:0] seconds_left;
	logic power_restored;
	logic shutdown;

	// Local copy of the monitor state.
	logic [GRACE_W-1:0] grace_copy;
	logic               accepted_pwr;
	logic               accepted_bat;
	logic [COUNT_W-1:0] differ_count;
	logic [FAIL_W-1:0]  battery_ticks;
	logic               shutdown_seen;

	ups_status_t pending_status[$];
	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	ups_power_fail_monitor #(
		.CONFIRM_SAMPLES(CONFIRM_SAMPLES),
		.REPORT_INTERVAL(REPORT_INTERVAL)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.grace_ticks   (grace_ticks),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mains_fail    (mains_fail),
		.battery_ok    (battery_ok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.held_sample   (held_sample),
		.power_ok      (power_ok),
		.fail_warning  (fail_warning),
		.seconds_left  (seconds_left),
		.power_restored(power_restored),
		.shutdown      (shutdown)
	);

	always #6 clk = ~clk;

	// Computes the status for one accepted sample and advances the local state.
	function automatic ups_status_t predict_status(input logic lf, input logic bo);
		ups_status_t r;
		logic        pwr;
		logic [31:0] twice_left;
		r = '0;
		pwr = ~lf;
		if (pwr != accepted_pwr || bo != accepted_bat) begin
			differ_count = differ_count + 1'b1;
			if (differ_count < CONFIRM_SAMPLES) begin
				r.held = 1'b1;
				r.pwr_ok = accepted_pwr;
				r.shut = shutdown_seen;
				return r;
			end
		end
		if (!pwr && !bo) begin
			shutdown_seen = 1'b1;
		end else if (!pwr) begin
			if (battery_ticks == 0 || battery_ticks % REPORT_INTERVAL == 0) begin
				r.warn = 1'b1;
				twice_left = (32'(grace_copy) - 32'(battery_ticks)) * 2;
				r.secs = twice_left[SECS_W-1:0];
			end
			if (battery_ticks > grace_copy)
				shutdown_seen = 1'b1;
			else
				battery_ticks = battery_ticks + 1'b1;
		end else if (battery_ticks != 0) begin
			r.restored = 1'b1;
			battery_ticks = '0;
		end
		differ_count = '0;
		accepted_pwr = pwr;
		accepted_bat = bo;
		r.pwr_ok = pwr;
		r.shut = shutdown_seen;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic signed [SECS_W-1:0] exp_v,
			input logic signed [SECS_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Result side: check each accepted beat, then pick the next ready level.
	always @(posedge clk) begin
		ups_status_t exp_s;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual held=%0b pwr=%0b",
					$realtime, held_sample, power_ok);
				mismatch_count++;
			end else begin
				exp_s = pending_status.pop_front();
				compare_field("held_sample", exp_s.held, held_sample);
				compare_field("power_ok", exp_s.pwr_ok, power_ok);
				compare_field("fail_warning", exp_s.warn, fail_warning);
				compare_field("seconds_left", exp_s.secs, seconds_left);
				compare_field("power_restored", exp_s.restored, power_restored);
				compare_field("shutdown", exp_s.shut, shutdown);
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Sends one sample beat after a random idle gap and records its status.
	task automatic send_sample(input logic lf, input logic bo);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			mains_fail <= 1'($urandom);
			battery_ok <= 1'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mains_fail <= lf;
		battery_ok <= bo;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_status.push_back(predict_status(lf, bo));
	endtask

	// Stops sending and waits until every outstanding status has come back.
	task automatic drain_status;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	// Writes the grace period while the monitor is idle.
	task automatic write_grace(input logic [GRACE_W-1:0] value);
		drain_status();
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		grace_ticks <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		grace_copy = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_run(input logic lf, input logic bo, input int count);
		repeat (count) send_sample(lf, bo);
	endtask

	// Glitches that stay under the confirm count, then a mixed change that confirms.
	task automatic test_debounce;
		send_run(1'b0, 1'b1, 2);
		send_run(1'b1, 1'b1, 3);
		send_sample(1'b0, 1'b1);
		drain_status();
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b1);
		send_sample(1'b1, 1'b1);
		send_run(1'b0, 1'b1, 4);
	endtask

	// A low battery with mains good changes the status but takes no action.
	task automatic test_low_battery_mains_good;
		send_run(1'b0, 1'b0, 4);
	endtask

	// With no grace the second tick on battery demands shutdown.
	task automatic test_grace_expiry;
		write_grace('0);
		send_run(1'b1, 1'b1, 6);
	endtask

	// Mains failed with a low battery shuts down at once.
	task automatic test_low_battery_fail;
		send_run(1'b1, 1'b0, 4);
		send_run(1'b0, 1'b1, 4);
	endtask

	// Mostly confirmed runs, long mains-failure runs or random content, plus glitches and noise.
	task automatic test_random_runs(input int count);
		int   sent;
		int   kind;
		int   len;
		logic lf;
		logic bo;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(9);
			lf = 1'($urandom);
			bo = 1'($urandom);
			if (kind == 0) begin
				len = 1;
			end else if (kind == 1) begin
				len = $urandom_range(1, CONFIRM_SAMPLES - 1);
			end else if (kind < 6) begin
				lf = 1'b1;
				bo = 1'b1;
				len = $urandom_range(CONFIRM_SAMPLES, 80);
			end else begin
				len = $urandom_range(CONFIRM_SAMPLES, 12);
			end
			send_run(lf, bo, len);
			sent += len;
		end
	endtask

	// Random phases under each idling pattern and several grace settings.
	task automatic test_random;
		idle_pct = 0;
		stall_pct = 0;
		write_grace(GRACE_MAX);
		test_random_runs(150);
		idle_pct = 60;
		write_grace(GRACE_W'($urandom_range(0, 70)));
		test_random_runs(150);
		idle_pct = 0;
		stall_pct = 60;
		write_grace(GRACE_W'(29));
		test_random_runs(150);
		idle_pct = 35;
		stall_pct = 35;
		write_grace(GRACE_W'($urandom));
		test_random_runs(75);
		write_grace(GRACE_W'(1));
		test_random_runs(75);
	endtask

	initial begin
		grace_copy = upsmon_pkg::GRACE_RESET;
		accepted_pwr = 1'b1;
		accepted_bat = 1'b1;
		differ_count = '0;
		battery_ticks = '0;
		shutdown_seen = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_debounce();
		test_low_battery_mains_good();
		test_grace_expiry();
		test_low_battery_fail();
		test_random();
		drain_status();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
